[hdl/pfla_pkg.sv]
// ----------------------------------------------------------------------------
// pfla_pkg
// shared constants and request/result types of the paired free-list allocator
// ----------------------------------------------------------------------------
`default_nettype none

package pfla_pkg;

  localparam int unsigned LIGHT_SLOTS_DEF  = 256;
  localparam int unsigned SHADOW_SLOTS_DEF = 16;

  localparam logic [1:0] OP_CREATE     = 2'd0;
  localparam logic [1:0] OP_REMOVE     = 2'd1;
  localparam logic [1:0] OP_SET_SHADOW = 2'd2;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_NO_LIGHT  = 2'd1;
  localparam logic [1:0] STATUS_NO_SHADOW = 2'd2;
  localparam logic [1:0] STATUS_BAD_INDEX = 2'd3;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] light_index;
    logic [2:0] cascade_count;
    logic       shadow_enable;
  } pfla_req_t;

  typedef struct packed {
    logic [7:0] handle;
    logic [3:0] shadow_slot;
    logic       shadow_held;
    logic [1:0] status;
    logic [8:0] lights_live;
    logic [4:0] shadows_live;
  } pfla_rsp_t;

endpackage

`default_nettype wire

[hdl/pfla_if.sv]
// ----------------------------------------------------------------------------
// pfla request and result channels
// valid/ready channels carrying the allocator payloads
// ----------------------------------------------------------------------------
`default_nettype none

interface pfla_req_if;
  logic                valid;
  logic                ready;
  pfla_pkg::pfla_req_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface pfla_rsp_if;
  logic                valid;
  logic                ready;
  pfla_pkg::pfla_rsp_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

[hdl/pfla_ram.sv]
// ----------------------------------------------------------------------------
// pfla_ram
// generic single-write, single-read memory with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module pfla_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[hdl/paired_free_list_handle_allocator_unit.sv]
// ----------------------------------------------------------------------------
// paired_free_list_handle_allocator_unit
// light and shadow slot pools kept as linked free lists in two memories
// ----------------------------------------------------------------------------
//  channel  dir  handshake      payload
//  req_i    in   valid & ready  operation, light_index, cascade_count,
//                               shadow_enable
//  rsp_o    out  valid & ready  handle, shadow_slot, shadow_held, status,
//                               lights_live, shadows_live
//
//  each request passes a memory read (accepted in ST_IDLE), then a modify and
//  write-back state (ST_EXEC); the result register loads at the end of ST_EXEC
//  the next request is taken in the cycle after the result is loaded, also
//  while that result still waits, as long as it is taken in that cycle
//  reset takes effect at once; untouched slots are tracked by fill counts,
//  so no clearing pass runs
// ----------------------------------------------------------------------------
`default_nettype none

module paired_free_list_handle_allocator_unit #(
  parameter int unsigned LIGHT_SLOTS  = pfla_pkg::LIGHT_SLOTS_DEF,
  parameter int unsigned SHADOW_SLOTS = pfla_pkg::SHADOW_SLOTS_DEF
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  pfla_req_if.sink    req_i,
  pfla_rsp_if.source  rsp_o
);

  import pfla_pkg::*;

  localparam int unsigned LW  = $clog2(LIGHT_SLOTS + 1);
  localparam int unsigned LA  = $clog2(LIGHT_SLOTS);
  localparam int unsigned SW  = $clog2(SHADOW_SLOTS + 1);
  localparam int unsigned SA  = (SHADOW_SLOTS > 1) ? $clog2(SHADOW_SLOTS) : 1;
  localparam int unsigned IW  = (LW > 8) ? LW : 8;
  localparam int unsigned LDW = 1 + SW + LW;

  typedef enum logic {ST_IDLE, ST_EXEC} state_e;

  typedef struct packed {
    logic          in_use;
    logic [SW-1:0] sref;
    logic [LW-1:0] link;
  } light_word_t;

  localparam logic [LW-1:0] LIGHT_END  = LW'(LIGHT_SLOTS);
  localparam logic [SW-1:0] SHADOW_END = SW'(SHADOW_SLOTS);

  state_e        state_q;
  logic          rsp_valid_q;
  pfla_req_t     req_q;
  logic [LA-1:0] laddr_q;
  pfla_rsp_t     rsp_q;
  pfla_rsp_t     rsp_d;

  logic [LW-1:0] light_head_q, light_head_d;
  logic [LW-1:0] light_fresh_q, light_fresh_d;
  logic [LW-1:0] light_total_q, light_total_d;
  logic [SW-1:0] shadow_head_q, shadow_head_d;
  logic [SW-1:0] shadow_fresh_q, shadow_fresh_d;
  logic [SW-1:0] shadow_total_q, shadow_total_d;

  logic          req_accept;
  logic [LA-1:0] light_raddr;
  logic [LDW-1:0] light_rdata;
  light_word_t   light_wword;
  logic          light_we;
  logic [SW-1:0] shadow_rdata;
  logic          shadow_we;
  logic [SA-1:0] shadow_waddr;
  logic [SW-1:0] shadow_wdata;

  assign req_i.ready = (state_q == ST_IDLE) && (!rsp_valid_q || rsp_o.ready);
  assign req_accept  = req_i.valid && req_i.ready;
  assign rsp_o.valid   = rsp_valid_q;
  assign rsp_o.payload = rsp_q;

  assign light_raddr = (req_i.payload.operation == OP_CREATE) ?
                       light_head_q[LA-1:0] : LA'(req_i.payload.light_index);

  pfla_ram #(
    .WIDTH (LDW),
    .DEPTH (LIGHT_SLOTS)
  ) u_light_ram (
    .clk_i   (clk_i),
    .we_i    (light_we),
    .waddr_i (laddr_q),
    .wdata_i (light_wword),
    .raddr_i (light_raddr),
    .rdata_o (light_rdata)
  );

  pfla_ram #(
    .WIDTH (SW),
    .DEPTH (SHADOW_SLOTS)
  ) u_shadow_ram (
    .clk_i   (clk_i),
    .we_i    (shadow_we),
    .waddr_i (shadow_waddr),
    .wdata_i (shadow_wdata),
    .raddr_i (shadow_head_q[SA-1:0]),
    .rdata_o (shadow_rdata)
  );

  always_comb begin
    light_word_t   lrd;
    logic          slot_free;
    logic          light_avail;
    logic          light_is_fresh;
    logic [LW-1:0] light_next;
    logic          shadow_avail;
    logic          shadow_is_fresh;
    logic [SW-1:0] shadow_next;
    logic          held;
    logic [SW-1:0] slot;

    lrd             = light_word_t'(light_rdata);
    slot_free       = (IW'(req_q.light_index) >= IW'(light_fresh_q)) || !lrd.in_use;
    light_avail     = light_head_q != LIGHT_END;
    light_is_fresh  = light_head_q == light_fresh_q;
    light_next      = light_is_fresh ? LW'(light_head_q + LW'(1)) : lrd.link;
    shadow_avail    = shadow_head_q != SHADOW_END;
    shadow_is_fresh = shadow_head_q == shadow_fresh_q;
    shadow_next     = shadow_is_fresh ? SW'(shadow_head_q + SW'(1)) : shadow_rdata;
    held            = 1'b0;
    slot            = SHADOW_END;

    light_head_d   = light_head_q;
    light_fresh_d  = light_fresh_q;
    light_total_d  = light_total_q;
    shadow_head_d  = shadow_head_q;
    shadow_fresh_d = shadow_fresh_q;
    shadow_total_d = shadow_total_q;

    light_we     = 1'b0;
    light_wword  = lrd;
    shadow_we    = 1'b0;
    shadow_waddr = lrd.sref[SA-1:0];
    shadow_wdata = shadow_head_q;

    rsp_d        = '0;
    rsp_d.handle = req_q.light_index;
    rsp_d.status = STATUS_OK;

    if (state_q == ST_EXEC) begin
      case (req_q.operation)
        OP_CREATE: begin
          rsp_d.handle = '0;
          if (!light_avail) begin
            rsp_d.status = STATUS_NO_LIGHT;
          end else begin
            rsp_d.handle  = 8'(light_head_q);
            light_head_d  = light_next;
            light_total_d = LW'(light_total_q + LW'(1));
            if (light_is_fresh) begin
              light_fresh_d = LW'(light_fresh_q + LW'(1));
            end
            if (req_q.cascade_count != 3'd0) begin
              if (shadow_avail) begin
                held           = 1'b1;
                slot           = shadow_head_q;
                shadow_head_d  = shadow_next;
                shadow_total_d = SW'(shadow_total_q + SW'(1));
                if (shadow_is_fresh) begin
                  shadow_fresh_d = SW'(shadow_fresh_q + SW'(1));
                end
              end else begin
                rsp_d.status = STATUS_NO_SHADOW;
              end
            end
            light_we           = 1'b1;
            light_wword.in_use = 1'b1;
            light_wword.sref   = slot;
          end
        end
        OP_REMOVE: begin
          if (slot_free) begin
            rsp_d.status = STATUS_BAD_INDEX;
          end else begin
            if (lrd.sref != SHADOW_END) begin
              shadow_we      = 1'b1;
              shadow_head_d  = lrd.sref;
              shadow_total_d = SW'(shadow_total_q - SW'(1));
            end
            light_we           = 1'b1;
            light_wword.in_use = 1'b0;
            light_wword.sref   = SHADOW_END;
            light_wword.link   = light_head_q;
            light_head_d       = LW'(req_q.light_index);
            light_total_d      = LW'(light_total_q - LW'(1));
          end
        end
        OP_SET_SHADOW: begin
          if (slot_free) begin
            rsp_d.status = STATUS_BAD_INDEX;
          end else if ((lrd.sref != SHADOW_END) == req_q.shadow_enable) begin
            held = req_q.shadow_enable;
            slot = lrd.sref;
          end else if (req_q.shadow_enable) begin
            if (shadow_avail) begin
              held             = 1'b1;
              slot             = shadow_head_q;
              shadow_head_d    = shadow_next;
              shadow_total_d   = SW'(shadow_total_q + SW'(1));
              if (shadow_is_fresh) begin
                shadow_fresh_d = SW'(shadow_fresh_q + SW'(1));
              end
              light_we         = 1'b1;
              light_wword.sref = shadow_head_q;
            end else begin
              rsp_d.status = STATUS_NO_SHADOW;
            end
          end else begin
            shadow_we        = 1'b1;
            shadow_head_d    = lrd.sref;
            shadow_total_d   = SW'(shadow_total_q - SW'(1));
            light_we         = 1'b1;
            light_wword.sref = SHADOW_END;
          end
        end
        default: begin
          rsp_d.status = STATUS_BAD_INDEX;
        end
      endcase
    end

    rsp_d.shadow_held  = held;
    rsp_d.shadow_slot  = held ? 4'(slot) : 4'd0;
    rsp_d.lights_live  = 9'(light_total_d);
    rsp_d.shadows_live = 5'(shadow_total_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      rsp_valid_q    <= 1'b0;
      light_head_q   <= '0;
      light_fresh_q  <= '0;
      light_total_q  <= '0;
      shadow_head_q  <= '0;
      shadow_fresh_q <= '0;
      shadow_total_q <= '0;
    end else begin
      if (rsp_valid_q && rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (req_accept) begin
            state_q <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          state_q        <= ST_IDLE;
          rsp_valid_q    <= 1'b1;
          light_head_q   <= light_head_d;
          light_fresh_q  <= light_fresh_d;
          light_total_q  <= light_total_d;
          shadow_head_q  <= shadow_head_d;
          shadow_fresh_q <= shadow_fresh_d;
          shadow_total_q <= shadow_total_d;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_accept) begin
      req_q   <= req_i.payload;
      laddr_q <= light_raddr;
    end
    if (state_q == ST_EXEC) begin
      rsp_q <= rsp_d;
    end
  end

  a_accept_then_exec : assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_accept |=> (state_q == ST_EXEC) && !rsp_valid_q)
    else $error("request accepted but no execute cycle followed");

  a_exec_loads_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EXEC) |=> rsp_valid_q && (state_q == ST_IDLE))
    else $error("execute cycle did not load the result register");

  a_shadow_owned : assert property (@(posedge clk_i) disable iff (!rst_ni)
    IW'(shadow_total_q) <= IW'(light_total_q))
    else $error("more shadow slots live than light slots");

  a_light_fill : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (light_total_q <= light_fresh_q) && (light_head_q <= light_fresh_q))
    else $error("light pool bookkeeping beyond fill count");

  a_shadow_fill : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (shadow_total_q <= shadow_fresh_q) && (shadow_head_q <= shadow_fresh_q))
    else $error("shadow pool bookkeeping beyond fill count");

endmodule

`default_nettype wire

[bench/testbench.sv]
// ----------------------------------------------------------------------------
// paired free-list allocator testbench
// drives create, remove, set-shadow and undefined requests with random gaps, predicts
// every result from a private copy of both free lists and checks each field
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import pfla_pkg::*;

  localparam int LIGHTS  = LIGHT_SLOTS_DEF;
  localparam int SHADOWS = SHADOW_SLOTS_DEF;
  localparam logic [1:0] OP_UNDEFINED = 2'd3;
  localparam int RANDOM_REQUESTS = 550;
  localparam int GROW_REQUESTS   = 320;
  localparam int BACKLOG_DEPTH   = 4;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  pfla_req_if req_if ();
  pfla_rsp_if rsp_if ();

  logic      drv_valid = 1'b0;
  pfla_req_t drv_item = '0;
  logic      sink_ready = 1'b0;

  assign req_if.valid   = drv_valid;
  assign req_if.payload = drv_item;
  assign rsp_if.ready   = sink_ready;

  paired_free_list_handle_allocator_unit uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // private copy of both pools
  logic [8:0] light_next   [LIGHTS];
  logic       light_used   [LIGHTS];
  logic [4:0] light_shadow [LIGHTS];
  logic [8:0] shadow_next  [SHADOWS];
  logic [8:0] light_head;
  logic [4:0] shadow_head;
  logic [8:0] light_count;
  logic [4:0] shadow_count;

  pfla_req_t alloc_requests[$];
  pfla_rsp_t alloc_outcomes[$];

  int unsigned issued_total = 0;
  int unsigned results_seen = 0;
  int unsigned fault_count  = 0;
  int unsigned idle_left    = 0;
  int unsigned stall_left   = 0;
  int unsigned hold_left    = 0;
  int unsigned hold_round   = 0;

  function automatic logic [4:0] take_shadow(logic [7:0] owner);
    logic [4:0] s;
    s = shadow_head;
    if (s >= SHADOWS) return SHADOWS[4:0];
    shadow_head = shadow_next[s[3:0]][4:0];
    shadow_next[s[3:0]] = {1'b0, owner};
    shadow_count++;
    return s;
  endfunction

  function automatic void give_shadow(logic [4:0] s);
    if (s >= SHADOWS) return;
    shadow_next[s[3:0]] = {4'd0, shadow_head};
    shadow_head = s;
    shadow_count--;
  endfunction

  function automatic void apply_alloc_op(pfla_req_t r);
    pfla_rsp_t  o;
    logic [7:0] idx;
    logic [4:0] s;
    logic [4:0] cur;
    logic       held;
    o = '0;
    idx = r.light_index;
    o.handle = idx;
    o.status = STATUS_OK;
    case (r.operation)
      OP_CREATE: begin
        o.handle = '0;
        if (light_head >= LIGHTS) begin
          o.status = STATUS_NO_LIGHT;
        end else begin
          idx = light_head[7:0];
          light_head = light_next[idx];
          light_used[idx] = 1'b1;
          light_count++;
          s = SHADOWS[4:0];
          if (r.cascade_count != 0) begin
            s = take_shadow(idx);
            if (s >= SHADOWS) o.status = STATUS_NO_SHADOW;
          end
          light_shadow[idx] = s;
          o.handle = idx;
          if (s < SHADOWS) begin
            o.shadow_slot = s[3:0];
            o.shadow_held = 1'b1;
          end
        end
      end
      OP_REMOVE, OP_SET_SHADOW: begin
        if (!light_used[idx]) begin
          o.status = STATUS_BAD_INDEX;
        end else if (r.operation == OP_REMOVE) begin
          give_shadow(light_shadow[idx]);
          light_shadow[idx] = SHADOWS[4:0];
          light_used[idx] = 1'b0;
          light_next[idx] = light_head;
          light_head = {1'b0, idx};
          light_count--;
        end else begin
          cur = light_shadow[idx];
          held = cur < SHADOWS;
          if (held == r.shadow_enable) begin
            if (held) begin
              o.shadow_slot = cur[3:0];
              o.shadow_held = 1'b1;
            end
          end else if (r.shadow_enable) begin
            s = take_shadow(idx);
            light_shadow[idx] = s;
            if (s < SHADOWS) begin
              o.shadow_slot = s[3:0];
              o.shadow_held = 1'b1;
            end else begin
              o.status = STATUS_NO_SHADOW;
            end
          end else begin
            give_shadow(cur);
            light_shadow[idx] = SHADOWS[4:0];
          end
        end
      end
      default: o.status = STATUS_BAD_INDEX;
    endcase
    o.lights_live  = light_count;
    o.shadows_live = shadow_count;
    alloc_outcomes = {alloc_outcomes, o};
  endfunction

  function automatic int unsigned idle_span(bit calm);
    int unsigned roll;
    if (calm) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 80) return $urandom_range(1, 2);
    if (roll < 95) return $urandom_range(3, 6);
    return $urandom_range(12, 40);
  endfunction

  function automatic logic [7:0] live_slot();
    int unsigned base;
    base = $urandom_range(0, LIGHTS - 1);
    for (int k = 0; k < LIGHTS; k++) begin
      if (light_used[(base + k) % LIGHTS]) return 8'((base + k) % LIGHTS);
    end
    return base[7:0];
  endfunction

  task automatic queue_request(logic [1:0] op, logic [7:0] idx, logic [2:0] casc,
                               logic en);
    pfla_req_t r;
    r.operation     = op;
    r.light_index   = idx;
    r.cascade_count = casc;
    r.shadow_enable = en;
    while (alloc_requests.size() >= BACKLOG_DEPTH) @(posedge clk_i);
    alloc_requests = {alloc_requests, r};
  endtask

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drv_valid <= 1'b0;
      drv_item  <= '0;
      idle_left <= 0;
    end else if (!drv_valid || req_if.ready) begin
      if (drv_valid) apply_alloc_op(drv_item);
      if (idle_left != 0) begin
        idle_left <= idle_left - 1;
        drv_valid <= 1'b0;
      end else if (alloc_requests.size() != 0) begin
        drv_valid <= 1'b1;
        drv_item  <= alloc_requests.pop_front();
        issued_total <= issued_total + 1;
        idle_left <= idle_span(((issued_total / 48) % 4) == 3);
      end else begin
        drv_valid <= 1'b0;
      end
    end
  end

  // result monitor
  always @(posedge clk_i or negedge rst_ni) begin
    pfla_rsp_t got;
    pfla_rsp_t exp;
    if (!rst_ni) begin
      sink_ready <= 1'b0;
      stall_left <= 0;
    end else begin
      if (rsp_if.valid && sink_ready) begin
        got = rsp_if.payload;
        results_seen <= results_seen + 1;
        if (alloc_outcomes.size() == 0) begin
          fault_count++;
          if (fault_count <= 10)
            $display("unexpected result: handle %0d status %0d", got.handle, got.status);
        end else begin
          exp = alloc_outcomes.pop_front();
          if (got.handle !== exp.handle || got.shadow_slot !== exp.shadow_slot ||
              got.shadow_held !== exp.shadow_held || got.status !== exp.status ||
              got.lights_live !== exp.lights_live ||
              got.shadows_live !== exp.shadows_live) begin
            fault_count++;
            if (fault_count <= 10) begin
              $display("mismatch at result %0d (exp/got): handle %0d/%0d slot %0d/%0d",
                       results_seen, exp.handle, got.handle, exp.shadow_slot,
                       got.shadow_slot);
              $display("  held %0b/%0b status %0d/%0d lights %0d/%0d shadows %0d/%0d",
                       exp.shadow_held, got.shadow_held, exp.status, got.status,
                       exp.lights_live, got.lights_live, exp.shadows_live,
                       got.shadows_live);
            end
          end
        end
      end
      if (hold_left != 0) begin
        sink_ready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        sink_ready <= 1'b0;
      end else begin
        sink_ready <= 1'b1;
        stall_left <= idle_span(((results_seen / 40) % 4) == 1);
      end
    end
  end

  // long receiver hold-off so the block backs up
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left  <= 0;
      hold_round <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if ((hold_round == 0 && results_seen >= 40) ||
                 (hold_round == 1 && results_seen >= 350)) begin
      hold_left  <= 200;
      hold_round <= hold_round + 1;
    end
  end

  initial begin
    int unsigned roll;
    logic [1:0]  op;
    logic [7:0]  idx;
    logic [2:0]  casc;
    bit          growing;
    for (int i = 0; i < LIGHTS; i++) begin
      light_next[i]   = 9'(i + 1);
      light_used[i]   = 1'b0;
      light_shadow[i] = SHADOWS[4:0];
    end
    for (int i = 0; i < SHADOWS; i++) shadow_next[i] = 9'(i + 1);
    light_head   = '0;
    shadow_head  = '0;
    light_count  = '0;
    shadow_count = '0;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed
    queue_request(OP_REMOVE,     8'd0,   3'd0, 1'b0);
    queue_request(OP_SET_SHADOW, 8'd255, 3'd7, 1'b1);
    queue_request(OP_UNDEFINED,  8'd0,   3'd0, 1'b0);
    queue_request(OP_CREATE,     8'd255, 3'd0, 1'b1);
    queue_request(OP_CREATE,     8'd0,   3'd4, 1'b0);
    queue_request(OP_CREATE,     8'd170, 3'd7, 1'b1);
    queue_request(OP_CREATE,     8'd85,  3'd1, 1'b0);
    queue_request(OP_SET_SHADOW, 8'd0,   3'd0, 1'b1);
    queue_request(OP_SET_SHADOW, 8'd0,   3'd2, 1'b1);
    queue_request(OP_SET_SHADOW, 8'd2,   3'd0, 1'b0);
    queue_request(OP_SET_SHADOW, 8'd2,   3'd0, 1'b0);
    queue_request(OP_REMOVE,     8'd1,   3'd7, 1'b1);
    queue_request(OP_REMOVE,     8'd1,   3'd0, 1'b0);
    queue_request(OP_SET_SHADOW, 8'd1,   3'd0, 1'b1);
    queue_request(OP_CREATE,     8'd0,   3'd3, 1'b0);
    queue_request(OP_REMOVE,     8'd255, 3'd0, 1'b0);
    queue_request(OP_UNDEFINED,  8'd255, 3'd7, 1'b1);

    // random: mostly creates until the light pool runs dry, then churn
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      growing = n < GROW_REQUESTS;
      roll = $urandom_range(0, 99);
      if (roll < (growing ? 92 : 25))      op = OP_CREATE;
      else if (roll < (growing ? 95 : 62)) op = OP_REMOVE;
      else if (roll < (growing ? 99 : 95)) op = OP_SET_SHADOW;
      else                                 op = OP_UNDEFINED;
      if (op == OP_CREATE || op == OP_UNDEFINED || $urandom_range(0, 99) < 15)
        idx = 8'($urandom_range(0, 255));
      else
        idx = live_slot();
      casc = ($urandom_range(0, 99) < 70) ? 3'($urandom_range(1, 7)) : 3'd0;
      queue_request(op, idx, casc, 1'($urandom_range(0, 1)));
    end

    while (alloc_requests.size() != 0 || drv_valid || alloc_outcomes.size() != 0)
      @(negedge clk_i);
    repeat (20) @(posedge clk_i);
    if (fault_count == 0)
      $display("** paired_free_list_handle_allocator_unit: PASSED **");
    else
      $display("** paired_free_list_handle_allocator_unit: FAILED **");
    $finish;
  end

  initial begin
    #1000000;
    $display("** paired_free_list_handle_allocator_unit: FAILED **");
    $finish;
  end

endmodule

`default_nettype wire
